// File: sv/dctt_pkg.sv
// ============================================================================
// dctt_pkg
// Shared types and constants for the dual crystal timer tick block.
// ============================================================================
`default_nettype none

package dctt_pkg;

    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned MASK_W    = 2;
    localparam int unsigned SPEED_W   = 2;
    localparam int unsigned CNT_W     = 20;
    localparam int unsigned EVENT_W   = 17;
    localparam int unsigned BASE_W    = 24;
    localparam int unsigned DIVR_W    = 11;
    localparam int unsigned PERIOD_W  = 18;
    localparam int unsigned STEPS_W   = 5;

    localparam logic [BASE_W-1:0]  BASE_FAST  = 24'd15000000;
    localparam logic [BASE_W-1:0]  BASE_SLOW  = 24'd6000000;
    localparam logic [STEPS_W-1:0] DIV_STEPS  = STEPS_W'(BASE_W);
    localparam logic signed [CNT_W:0] CNT_MIN = -21'sd524288;
    localparam logic signed [CNT_W:0] EVT_CAP = 21'sd1000;
    localparam logic signed [CNT_W:0] EVT_FLOOR = -21'sd65535;

    // APB register indexes.
    localparam logic REG_SPEED    = 1'b0;
    localparam logic REG_CPU_FAST = 1'b1;

    // Input item modes.
    localparam logic MODE_ADVANCE = 1'b0;
    localparam logic MODE_MASK    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic latch;
        logic div_start;
        logic div_step;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

    // Ticks per timer step: 32768 / (64 + 80 * speed).
    function automatic logic [9:0] speed_step(input logic [SPEED_W-1:0] speed);
        logic [9:0] res;
        unique case (speed)
            2'd0:    res = 10'd512;
            2'd1:    res = 10'd227;
            2'd2:    res = 10'd146;
            default: res = 10'd107;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/dctt_in_if.sv
// ============================================================================
// dctt_in_if
// Input channel: one timer transaction with valid/ready handshake.
// ============================================================================
`default_nettype none

interface dctt_in_if;
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [15:0]           elapsed;
    logic [1:0]            new_enable;

    modport source (output valid, mode, elapsed, new_enable, input ready);
    modport sink   (input valid, mode, elapsed, new_enable, output ready);
endinterface

`default_nettype wire

// File: sv/dctt_out_if.sv
// ============================================================================
// dctt_out_if
// Output channel: fired mask and next event count with valid/ready handshake.
// ============================================================================
`default_nettype none

interface dctt_out_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            fired;
    logic signed [16:0]    next_event;

    modport source (output valid, fired, next_event, input ready);
    modport sink   (input valid, fired, next_event, output ready);
endinterface

`default_nettype wire

// File: sv/dctt_ctrl.sv
// ============================================================================
// dctt_ctrl
// Controller: sequences capture, period division and timer update.
// ============================================================================
`default_nettype none

module dctt_ctrl
    import dctt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    output t_cmd         o_cmd,
    input  wire t_status i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The result register can take a new value when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV:   if (i_sts.div_done) n_state = ST_WRITE;
            ST_WRITE: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_START: o_cmd.div_start = 1'b1;
            ST_DIV:   o_cmd.div_step  = 1'b1;
            ST_WRITE: o_cmd.update    = out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.update) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: sv/dctt_dp.sv
// ============================================================================
// dctt_dp
// Datapath: timer counts, serial period divider and result register.
// ============================================================================
`default_nettype none

module dctt_dp
    import dctt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_sts,
    input  wire logic [SPEED_W-1:0]    i_speed,
    input  wire logic                  i_cpu_fast,
    input  wire logic                  i_mode,
    input  wire logic [ELAPSED_W-1:0]  i_elapsed,
    input  wire logic [MASK_W-1:0]     i_new_enable,
    output logic [MASK_W-1:0]          o_fired,
    output logic signed [EVENT_W-1:0]  o_next_event
);

    logic                    r_mode;
    logic [ELAPSED_W-1:0]    r_elapsed;
    logic [MASK_W-1:0]       r_new_en;
    logic [MASK_W-1:0]       r_en_mask, n_en_mask;
    logic signed [CNT_W-1:0] r_rem [MASK_W];
    logic signed [CNT_W-1:0] n_rem [MASK_W];
    logic [MASK_W-1:0]       r_fired, n_fired;
    logic signed [EVENT_W-1:0] r_next, n_next;

    logic [DIVR_W-1:0]       r_div;
    logic [BASE_W-1:0]       r_dvd;
    logic [DIVR_W-1:0]       r_part;
    logic [STEPS_W-1:0]      r_cnt;

    logic [MASK_W-1:0]       eff_mask;
    logic [DIVR_W-1:0]       divisor;
    logic [DIVR_W:0]         part_sh;
    logic [DIVR_W:0]         part_sub;
    logic                    part_ge;
    logic [PERIOD_W-1:0]     period;
    logic signed [CNT_W:0]   period_s;

    // Mask in force once this transaction is applied.
    assign eff_mask = (r_mode == MODE_MASK) ? r_new_en : r_en_mask;
    assign divisor  = {1'b0, speed_step(i_speed)} * DIVR_W'(eff_mask);

    // Restoring division, one quotient bit per cycle shifted into the dividend.
    assign part_sh  = {r_part, r_dvd[BASE_W-1]};
    assign part_ge  = part_sh >= {1'b0, r_div};
    assign part_sub = part_sh - {1'b0, r_div};
    assign o_sts.div_done = (r_cnt == '0);

    assign period   = (r_div == '0) ? '0 : r_dvd[PERIOD_W-1:0];
    assign period_s = signed'({{(CNT_W + 1 - PERIOD_W){1'b0}}, period});

    always_comb begin
        logic signed [CNT_W:0] v;
        logic signed [CNT_W:0] best;
        n_en_mask = eff_mask;
        n_fired   = '0;
        best      = EVT_CAP;
        for (int i = 0; i < MASK_W; i++) begin
            n_rem[i] = r_rem[i];
            v = '0;
            if (r_mode == MODE_MASK) begin
                if (r_new_en[i] && !r_en_mask[i]) begin
                    n_rem[i] = period_s[CNT_W-1:0];
                end else if (!r_new_en[i] && r_en_mask[i]) begin
                    n_rem[i] = '0;
                end
            end else if (r_en_mask[i]) begin
                v = {r_rem[i][CNT_W-1], r_rem[i]}
                    - signed'({{(CNT_W + 1 - ELAPSED_W){1'b0}}, r_elapsed});
                if (v < CNT_MIN) v = CNT_MIN;
                if (v <= 0) begin
                    n_fired[i] = 1'b1;
                    v = v + period_s;
                end
                n_rem[i] = v[CNT_W-1:0];
            end
            if (n_en_mask[i] && (signed'({n_rem[i][CNT_W-1], n_rem[i]}) < best)) begin
                best = {n_rem[i][CNT_W-1], n_rem[i]};
            end
        end
        if (best < EVT_FLOOR) best = EVT_FLOOR;
        n_next = best[EVENT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_mask <= '0;
            r_cnt     <= '0;
            for (int i = 0; i < MASK_W; i++) r_rem[i] <= '0;
        end else begin
            if (i_cmd.div_start) begin
                r_cnt <= DIV_STEPS;
            end else if (i_cmd.div_step && r_cnt != '0) begin
                r_cnt <= r_cnt - STEPS_W'(1);
            end
            if (i_cmd.update) begin
                r_en_mask <= n_en_mask;
                for (int i = 0; i < MASK_W; i++) r_rem[i] <= n_rem[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode    <= i_mode;
            r_elapsed <= i_elapsed;
            r_new_en  <= i_new_enable;
        end
        if (i_cmd.div_start) begin
            r_div  <= divisor;
            r_dvd  <= i_cpu_fast ? BASE_FAST : BASE_SLOW;
            r_part <= '0;
        end else if (i_cmd.div_step && r_cnt != '0) begin
            r_part <= part_ge ? part_sub[DIVR_W-1:0] : part_sh[DIVR_W-1:0];
            r_dvd  <= {r_dvd[BASE_W-2:0], part_ge};
        end
        if (i_cmd.update) begin
            r_fired <= n_fired;
            r_next  <= n_next;
        end
    end

    assign o_fired      = r_fired;
    assign o_next_event = r_next;

endmodule

`default_nettype wire

// File: sv/dual_crystal_timer_tick_top.sv
// ============================================================================
// dual_crystal_timer_tick_top
// Two countdown timers advanced by elapsed clock states, with APB setup.
// ============================================================================
// Each transaction is captured, then the 24-step serial divider forms the
// timer period, and then the counts and the result register are updated;
// a new transaction is taken only after that update.
// The result sits in an output register; the next transaction is accepted
// while it waits, and its update stalls only until that result is taken.
// Reset (synchronous, active low) disables both timers, clears their counts
// and the result valid, and sets timer_speed to 3 and cpu_fast to 0.
`default_nettype none

module dual_crystal_timer_tick_top
    import dctt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    dctt_in_if.sink          i_in,
    dctt_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers. Register index is address bit 2, so every
    // address maps onto one of the two registers.
    logic [SPEED_W-1:0] r_speed;
    logic               r_cpu_fast;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= 2'd3;
            r_cpu_fast <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SPEED:    r_speed    <= pwdata[SPEED_W-1:0];
                REG_CPU_FAST: r_cpu_fast <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_SPEED:    prdata = {{(32 - SPEED_W){1'b0}}, r_speed};
            REG_CPU_FAST: prdata = {31'd0, r_cpu_fast};
            default: ;
        endcase
    end

    // The controller sequences each transaction; the datapath holds the
    // timer counts, the period divider and the result register.
    t_cmd    cmd;
    t_status sts;

    dctt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dctt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_speed      (r_speed),
        .i_cpu_fast   (r_cpu_fast),
        .i_mode       (i_in.mode),
        .i_elapsed    (i_in.elapsed),
        .i_new_enable (i_in.new_enable),
        .o_fired      (o_out.fired),
        .o_next_event (o_out.next_event)
    );

endmodule

`default_nettype wire

// File: verif/tb.sv
// ============================================================================
// tb
// Self-checking bench for the dual crystal timer tick block. A directed table
// and random sequences go through the input channel across several register
// settings. Every output transaction is compared field by field with the
// result typed into its directed row, or else with a software copy of the two timers.
// ============================================================================

module tb;
    import dctt_pkg::*;

    // One row of stimulus. When known is set, the expected result is the one
    // typed into the row; otherwise it comes from the timer predictor.
    typedef struct packed {
        logic               mode;
        logic [15:0]        elapsed;
        logic [1:0]         new_enable;
        logic               known;
        logic [1:0]         fired;
        logic signed [16:0] next_event;
    } tick_row_t;

    typedef struct packed {
        logic [1:0]         fired;
        logic signed [16:0] next_event;
    } tick_result_t;

    localparam int N_DIRECTED      = 24;
    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int DRAIN_CYCLES    = 60;
    localparam int COUNT_SAT       = -524288;
    localparam int EVENT_CAP       = 1000;
    localparam int EVENT_FLOOR     = -65535;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    dctt_in_if  in_ch ();
    dctt_out_if out_ch ();

    dual_crystal_timer_tick_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: the register settings, the enable mask and the two
    // counts, kept in plain ints so that underflow is easy to see.
    logic [1:0] cur_speed;
    logic       cur_fast;
    logic [1:0] cur_mask;
    int         cnt [2];

    tick_result_t pending_ticks [$];
    tick_result_t head_result;
    tick_row_t    directed_rows [N_DIRECTED];
    int           mismatches    = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           burst_left    = 0;

    // Timer period for the given settings; a zero divisor gives zero.
    function automatic int period_for(input logic [1:0] speed, input logic fast,
                                      input logic [1:0] mask);
        int base;
        int ticks;
        int divisor;
        base    = fast ? 15000000 : 6000000;
        ticks   = 32768 / (64 + 80 * int'(speed));
        divisor = ticks * int'(mask);
        if (divisor == 0) return 0;
        return base / divisor;
    endfunction

    // Applies one input transaction to the predictor and returns the result.
    task automatic step_timers(input logic mode, input logic [15:0] elapsed,
                               input logic [1:0] new_en, output tick_result_t res);
        logic [1:0] old_mask;
        int         per;
        int         v;
        int         best;
        res.fired = '0;
        if (mode == MODE_MASK) begin
            old_mask = cur_mask;
            cur_mask = new_en;
            per      = period_for(cur_speed, cur_fast, cur_mask);
            for (int i = 0; i < 2; i++) begin
                if (new_en[i] && !old_mask[i]) cnt[i] = per;
                if (old_mask[i] && !new_en[i]) cnt[i] = 0;
            end
        end else begin
            per = period_for(cur_speed, cur_fast, cur_mask);
            for (int i = 0; i < 2; i++) begin
                if (cur_mask[i]) begin
                    v = cnt[i] - int'(elapsed);
                    if (v < COUNT_SAT) v = COUNT_SAT;
                    if (v <= 0) begin
                        res.fired[i] = 1'b1;
                        v += per;
                    end
                    cnt[i] = v;
                end
            end
        end
        best = EVENT_CAP;
        for (int i = 0; i < 2; i++) begin
            if (cur_mask[i] && cnt[i] < best) best = cnt[i];
        end
        if (best < EVENT_FLOOR) best = EVENT_FLOOR;
        res.next_event = 17'(best);
    endtask

    // Random item generator. Most items advance time; some land on a timer's
    // count or one off it, some are runs of maximum elapsed values that drive
    // the counts into saturation, and some rewrite the enable mask.
    task automatic next_random_item(output tick_row_t row);
        int pick;
        int k;
        row            = '0;
        row.mode       = MODE_ADVANCE;
        row.elapsed    = 16'($urandom());
        row.new_enable = 2'($urandom());
        if (burst_left > 0) begin
            burst_left--;
            row.elapsed = 16'hFFFF;
        end else begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                burst_left  = $urandom_range(14, 6);
                row.elapsed = 16'hFFFF;
            end else if (pick < 16) begin
                row.mode = MODE_MASK;
            end else if (pick < 46) begin
                row.elapsed = 16'($urandom_range(1000));
            end else if (pick < 76) begin
                k = $urandom_range(1);
                if (cur_mask[k] && cnt[k] >= 1 && cnt[k] <= 65534)
                    row.elapsed = 16'(cnt[k] - 1 + int'($urandom_range(2)));
            end
        end
    endtask

    // Sends one transaction, with a random gap in front of it. The valid line
    // is only lowered when a gap is actually taken, so back-to-back items
    // keep it high.
    task automatic send_item(input tick_row_t row);
        tick_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.mode       = row.mode;
        in_ch.elapsed    = row.elapsed;
        in_ch.new_enable = row.new_enable;
        in_ch.valid      = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        step_timers(row.mode, row.elapsed, row.new_enable, res);
        if (row.known) begin
            res.fired      = row.fired;
            res.next_event = row.next_event;
        end
        pending_ticks.push_back(res);
        @(negedge i_clk);
    endtask

    // Holds the input channel quiet until every expected result is back.
    task automatic wait_for_drain();
        in_ch.valid = 1'b0;
        while (pending_ticks.size() != 0) @(negedge i_clk);
    endtask

    // APB write, then a read back of the same register. Only the bits the
    // register holds are compared; the upper write bits are random junk.
    task automatic reg_write(input logic idx, input logic [1:0] value);
        logic [31:0] word;
        word      = $urandom();
        word[1:0] = value;
        psel      = 1'b1;
        penable   = 1'b0;
        pwrite    = 1'b1;
        paddr     = {idx, 2'b00};
        pwdata    = word;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SPEED) cur_speed = value;
        else cur_fast = value[0];
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((idx == REG_SPEED && prdata[1:0] != value)
                || (idx == REG_CPU_FAST && prdata[0] != value[0])) begin
            $display("%0t: register %0d read back, expected %0d, got %0d",
                     $time, idx, value, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // The receiver stalls at random; the stall is decided at the falling edge
    // so the block sees a stable ready at the next rising edge.
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: every output transaction is matched against the oldest
    // pending expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_ticks.size() == 0) begin
                $display("%0t: result with none expected, got fired %0d next_event %0d",
                         $time, out_ch.fired, out_ch.next_event);
                mismatches++;
            end else begin
                head_result = pending_ticks.pop_front();
                if (out_ch.fired !== head_result.fired) begin
                    $display("%0t: fired mismatch, expected %0d, got %0d",
                             $time, head_result.fired, out_ch.fired);
                    mismatches++;
                end
                if (out_ch.next_event !== head_result.next_event) begin
                    $display("%0t: next_event mismatch, expected %0d, got %0d",
                             $time, head_result.next_event, out_ch.next_event);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        tick_row_t row;
        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_ADVANCE;
        in_ch.elapsed    = '0;
        in_ch.new_enable = '0;
        out_ch.ready     = 1'b0;

        // The directed table starts from the reset settings: speed 3 and the
        // slow base, so a single timer period is 56074, two-bit mask 2 gives
        // 28037 and mask 3 gives 18691.
        directed_rows = '{
            // Nothing enabled: no fire, the event count sits at its cap.
            '{MODE_ADVANCE, 16'd0,     2'd0, 1'b1, 2'b00, 17'sd1000},
            '{MODE_ADVANCE, 16'hFFFF,  2'd2, 1'b1, 2'b00, 17'sd1000},
            '{MODE_MASK,    16'd0,     2'd0, 1'b1, 2'b00, 17'sd1000},
            // Enable timer 0; elapsed is ignored on a mask write.
            '{MODE_MASK,    16'hFFFF,  2'd1, 1'b1, 2'b00, 17'sd1000},
            // One state short of zero, then exactly zero, then a full period.
            '{MODE_ADVANCE, 16'd56073, 2'd3, 1'b1, 2'b00, 17'sd1},
            '{MODE_ADVANCE, 16'd1,     2'd0, 1'b1, 2'b01, 17'sd1000},
            '{MODE_ADVANCE, 16'd56074, 2'd0, 1'b1, 2'b01, 17'sd1000},
            // Both on, then fall behind by the largest step several times.
            '{MODE_MASK,    16'd0,     2'd3, 1'b1, 2'b00, 17'sd1000},
            '{MODE_ADVANCE, 16'hFFFF,  2'd0, 1'b0, 2'b00, 17'sd0},
            '{MODE_ADVANCE, 16'hFFFF,  2'd1, 1'b0, 2'b00, 17'sd0},
            '{MODE_ADVANCE, 16'hFFFF,  2'd2, 1'b0, 2'b00, 17'sd0},
            // Drop timer 0, then rewrite the same mask: no reload.
            '{MODE_MASK,    16'd0,     2'd2, 1'b0, 2'b00, 17'sd0},
            '{MODE_MASK,    16'd1234,  2'd2, 1'b0, 2'b00, 17'sd0},
            '{MODE_ADVANCE, 16'd0,     2'd0, 1'b0, 2'b00, 17'sd0},
            '{MODE_MASK,    16'd0,     2'd0, 1'b1, 2'b00, 17'sd1000},
            // Timer 1 alone uses the period for mask value 2.
            '{MODE_MASK,    16'd0,     2'd2, 1'b1, 2'b00, 17'sd1000},
            '{MODE_ADVANCE, 16'd28037, 2'd0, 1'b1, 2'b10, 17'sd1000},
            '{MODE_ADVANCE, 16'd28036, 2'd0, 1'b1, 2'b00, 17'sd1},
            // Swap timers in one write: timer 0 loads, timer 1 clears.
            '{MODE_MASK,    16'd0,     2'd1, 1'b1, 2'b00, 17'sd1000},
            '{MODE_ADVANCE, 16'd0,     2'd0, 1'b1, 2'b00, 17'sd1000},
            '{MODE_MASK,    16'd0,     2'd3, 1'b0, 2'b00, 17'sd0},
            '{MODE_ADVANCE, 16'd18000, 2'd0, 1'b0, 2'b00, 17'sd0},
            '{MODE_ADVANCE, 16'hAAAA,  2'd3, 1'b0, 2'b00, 17'sd0},
            '{MODE_ADVANCE, 16'h5555,  2'd0, 1'b0, 2'b00, 17'sd0}
        };

        cur_speed = 2'd3;
        cur_fast  = 1'b0;
        cur_mask  = 2'd0;
        cnt[0]    = 0;
        cnt[1]    = 0;

        // Idling plan: the first third of the run has a lazy sender and a
        // heavily stalling receiver, the second third the reverse, and the
        // last third runs at full rate on both sides.
        send_idle_pct = 28;
        recv_idle_pct = 77;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) send_item(directed_rows[r]);

        // Each phase changes both registers while the block is idle. The
        // counts carry over, so periods loaded under the old settings keep
        // running until they reload under the new ones.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_for_drain();
            send_idle_pct = (ph / 3 == 0) ? 28 : (ph / 3 == 1) ? 77 : 0;
            recv_idle_pct = (ph / 3 == 0) ? 77 : (ph / 3 == 1) ? 28 : 0;
            reg_write(REG_SPEED, 2'((ph * 3) % 4));
            reg_write(REG_CPU_FAST, {1'($urandom()), (ph % 3 == 1)});
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                next_random_item(row);
                send_item(row);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: the expected run is well under a tenth of this.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/dctt_pkg.sv
sv/dctt_in_if.sv
sv/dctt_out_if.sv
sv/dctt_ctrl.sv
sv/dctt_dp.sv
sv/dual_crystal_timer_tick_top.sv
verif/tb.sv
